/* design/cfk_pkg.sv */
// ----------------------------------------------------------------------------
// cfk_pkg
// shared widths, codes, angle table and helpers for the tilt filter
// ----------------------------------------------------------------------------
package cfk_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int TAB_IDX_W    = 5;
  localparam int VEC_W        = 36;
  localparam int ANG_W        = 30;
  localparam int ACC_W        = 26;
  localparam int TAB_W        = 26;

  localparam int DIV_W        = 36;
  localparam int DIV_CNT_W    = $clog2(DIV_W);
  localparam int REM_W        = 8;
  localparam logic [REM_W:0] DIV_CONST = 9'd164;

  localparam int MCAND_W      = 34;
  localparam int MPLR_W       = 16;
  localparam int MUL_CNT_W    = $clog2(MPLR_W);
  localparam int PROD_W       = MCAND_W + MPLR_W;

  localparam int CFG_IDX_W    = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PITCH,
    ST_YAW,
    ST_BLEND,
    ST_DONE
  } seq_state_t;

  // arctangent of 2^-i in degrees, 20 fraction bits
  function automatic logic [TAB_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      5'd0:    v = 26'd47185920;
      5'd1:    v = 26'd27855475;
      5'd2:    v = 26'd14718068;
      5'd3:    v = 26'd7471121;
      5'd4:    v = 26'd3750058;
      5'd5:    v = 26'd1876857;
      5'd6:    v = 26'd938658;
      5'd7:    v = 26'd469357;
      5'd8:    v = 26'd234682;
      5'd9:    v = 26'd117342;
      5'd10:   v = 26'd58671;
      5'd11:   v = 26'd29335;
      5'd12:   v = 26'd14668;
      5'd13:   v = 26'd7334;
      5'd14:   v = 26'd3667;
      5'd15:   v = 26'd1833;
      5'd16:   v = 26'd917;
      5'd17:   v = 26'd458;
      5'd18:   v = 26'd229;
      5'd19:   v = 26'd115;
      5'd20:   v = 26'd57;
      5'd21:   v = 26'd29;
      5'd22:   v = 26'd14;
      5'd23:   v = 26'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  // whole degrees, truncated toward zero, saturated to 16 bits
  function automatic logic signed [15:0] whole16(input logic signed [39:0] v);
    logic signed [23:0] t;
    logic signed [15:0] r;
    t = v[39:16];
    if (v[39] && (v[15:0] != 16'd0)) begin
      t = t + 24'sd1;
    end
    if (t > 24'sd32767) begin
      r = 16'sh7fff;
    end else if (t < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage

/* design/cfk_cordic.sv */
// ----------------------------------------------------------------------------
// cfk_cordic
// vectoring cordic, one rotation per cycle, atan2(x accel, z accel) in degrees
// ----------------------------------------------------------------------------
module cfk_cordic
  import cfk_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [15:0]       accel_x,
  input  logic signed [15:0]       accel_z,
  output logic                     busy,
  output logic signed [ACC_W-1:0]  angle
);

  logic signed [VEC_W-1:0] x_r, x_nxt, y_r, y_nxt, tx, ty, x0, y0;
  logic signed [ANG_W-1:0] z_r, z_nxt, z0, tab, zr;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    busy_r, busy_nxt, zero_r, zero_nxt;

  assign x0 = {{4{accel_z[15]}}, accel_z, 16'b0};
  assign y0 = {{4{accel_x[15]}}, accel_x, 16'b0};
  assign tx = x_r >>> step_r;
  assign ty = y_r >>> step_r;
  assign tab = {{(ANG_W-TAB_W){1'b0}}, atan_entry(TAB_IDX_W'(step_r))};

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    z0 = '0;
    if (start) begin
      zero_nxt = (accel_x == 16'sd0) && (accel_z == 16'sd0);
      step_nxt = '0;
      busy_nxt = 1'b1;
      if (accel_z[15]) begin
        x_nxt = -x0;
        y_nxt = -y0;
        z0 = accel_x[15] ? -30'sd188743680 : 30'sd188743680;
      end else begin
        x_nxt = x0;
        y_nxt = y0;
      end
      z_nxt = z0;
    end else if (busy_r) begin
      if (!y_r[VEC_W-1]) begin
        x_nxt = x_r + ty;
        y_nxt = y_r - tx;
        z_nxt = z_r + tab;
      end else begin
        x_nxt = x_r - ty;
        y_nxt = y_r + tx;
        z_nxt = z_r - tab;
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    zero_r <= zero_nxt;
  end

  // round 20 fraction bits down to 16
  assign zr = z_r + 30'sd8;
  assign angle = zero_r ? '0 : zr[ANG_W-1:4];
  assign busy = busy_r;

  property p_step_zero_when_idle;
    @(posedge clk) disable iff (!rst_n) (busy_r && !busy_nxt) |=> (step_r == '0);
  endproperty
  a_step_zero_when_idle: assert property (p_step_zero_when_idle)
    else $error("cordic step counter did not wrap at the end of a run");

  property p_start_runs;
    @(posedge clk) disable iff (!rst_n) start |=> busy_r && (step_r == '0);
  endproperty
  a_start_runs: assert property (p_start_runs)
    else $error("cordic did not begin a run after start");

  property p_zero_angle;
    @(posedge clk) disable iff (!rst_n) (!busy_r && zero_r) |-> (angle == '0);
  endproperty
  a_zero_angle: assert property (p_zero_angle)
    else $error("zero vector gave a nonzero angle");

endmodule

/* design/cfk_cdiv.sv */
// ----------------------------------------------------------------------------
// cfk_cdiv
// bit-serial restoring divider by the constant 164, one quotient bit a cycle
// ----------------------------------------------------------------------------
module cfk_cdiv
  import cfk_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0]     num_r, num_nxt, quo_r, quo_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, qbit;
  logic [REM_W:0]       trial, diff;

  assign trial = {rem_r, num_r[DIV_W-1]};
  assign qbit  = (trial >= DIV_CONST);
  assign diff  = trial - DIV_CONST;

  always_comb begin
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      num_nxt = dividend;
      quo_nxt = '0;
      rem_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_W-2:0], 1'b0};
      quo_nxt = {quo_r[DIV_W-2:0], qbit};
      rem_nxt = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign quotient = quo_r;

  property p_rem_bound;
    @(posedge clk) disable iff (!rst_n) busy_r |-> (rem_r < DIV_CONST[REM_W-1:0]);
  endproperty
  a_rem_bound: assert property (p_rem_bound)
    else $error("partial remainder reached the divisor");

  property p_start_clears;
    @(posedge clk) disable iff (!rst_n) start |=> busy_r && (rem_r == '0) && (cnt_r == '0);
  endproperty
  a_start_clears: assert property (p_start_clears)
    else $error("divider not cleared on start");

  property p_finish;
    @(posedge clk) disable iff (!rst_n)
      (busy_r && !start && (cnt_r == DIV_CNT_W'(DIV_W - 1))) |=> !busy_r;
  endproperty
  a_finish: assert property (p_finish)
    else $error("divider ran past its last bit");

endmodule

/* design/cfk_smul.sv */
// ----------------------------------------------------------------------------
// cfk_smul
// serial shift-add multiplier, signed multiplicand by unsigned 16-bit weight
// ----------------------------------------------------------------------------
module cfk_smul
  import cfk_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [MCAND_W-1:0] mcand,
  input  logic [MPLR_W-1:0]         mplr,
  output logic                      busy,
  output logic signed [PROD_W-1:0]  prod
);

  logic signed [PROD_W-1:0] acc_r, acc_nxt, mc_r, mc_nxt;
  logic [MPLR_W-1:0]        mp_r, mp_nxt;
  logic [MUL_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mc_nxt = mc_r;
    mp_nxt = mp_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt = '0;
      mc_nxt = {{MPLR_W{mcand[MCAND_W-1]}}, mcand};
      mp_nxt = mplr;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt = mc_r <<< 1;
      mp_nxt = mp_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MPLR_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      acc_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
    end
    mc_r <= mc_nxt;
    mp_r <= mp_nxt;
  end

  assign busy = busy_r;
  assign prod = acc_r;

  property p_start_loads;
    @(posedge clk) disable iff (!rst_n) start |=> busy_r && (acc_r == '0);
  endproperty
  a_start_loads: assert property (p_start_loads)
    else $error("multiplier not cleared on start");

  property p_hold_after;
    @(posedge clk) disable iff (!rst_n) (!busy_r && !start) |=> $stable(acc_r);
  endproperty
  a_hold_after: assert property (p_hold_after)
    else $error("product changed while idle");

  property p_finish;
    @(posedge clk) disable iff (!rst_n)
      (busy_r && !start && (cnt_r == MUL_CNT_W'(MPLR_W - 1))) |=> !busy_r;
  endproperty
  a_finish: assert property (p_finish)
    else $error("multiplier ran past its last bit");

endmodule

/* design/imu_tilt_complementary_filter.sv */
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter
// complementary pitch filter with cordic accel pitch and gyro yaw integration
// ----------------------------------------------------------------------------
// in_*  : one imu sample per word (x and z accel, y and z rate, signed 16 bit)
// out_* : one result word per sample: pitch, yaw, pitch_valid
// cfg_* : register writes (0 blend weight, 1 sample period, 2 warm-up count),
//         always ready, write only while no sample is in flight; index 3 is ignored
// one sample is worked at a time; in_ready is high only while idle
// from input word to output word a sample passes these steps in order:
//   serial divide for the gyro pitch term (cordic runs alongside),
//   serial divide for the yaw rate, serial blend multiply, with a step
//   each to start the yaw divide, start the multiply, finish the blend
//   and load the output
// a new sample is taken only once the last one is finished, and each
// sample makes two passes through the bit-serial divider
// a finished word waits in the output register; if the receiver stalls the
// next sample may still be taken and worked, then waits for the register
// reset clears pitch, yaw and sample count and loads the default registers
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter
  import cfk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    in_accel_x_raw,
  input  logic signed [15:0]    in_accel_z_raw,
  input  logic signed [15:0]    in_rate_y_raw,
  input  logic signed [15:0]    in_rate_z_raw,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_pitch_deg,
  output logic signed [15:0]    out_yaw_deg,
  output logic                  out_pitch_valid,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]           cfg_data
);

  seq_state_t state_r, state_nxt;

  logic [15:0]        blend_r, period_r, warmup_r, count_r, count_nxt;
  logic signed [31:0] fp_r;
  logic signed [39:0] yaw_r;
  logic signed [15:0] held_r, held_nxt;
  logic               valid_r, pitch_neg_r, yaw_neg_r;
  logic [18:0]        yaw_mag_r;
  logic signed [33:0] a_r;

  logic               accept, out_free;
  logic signed [32:0] gp;
  logic signed [35:0] gp10, gp_mag;
  logic signed [19:0] gz10, gz_mag;

  logic               cor_busy, div_busy, mul_busy;
  logic signed [ACC_W-1:0] acc_angle;
  logic               div_start, mul_start;
  logic [DIV_W-1:0]   div_dividend, div_quo;
  logic signed [PROD_W-1:0] prod;

  logic signed [29:0] dq, delta;
  logic signed [33:0] a_nxt, d;
  logic signed [12:0] yq;
  logic signed [21:0] inc;
  logic signed [40:0] yaw_sum;
  logic signed [39:0] yaw_sat;
  logic signed [51:0] b;
  logic signed [35:0] bs;
  logic signed [31:0] fp_sat;

  assign accept = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  // gyro pitch numerator rate_y * dt * 10, as sign and rounded magnitude
  assign gp = in_rate_y_raw * $signed({1'b0, period_r});
  assign gp10 = ({{3{gp[32]}}, gp} <<< 3) + ({{3{gp[32]}}, gp} <<< 1);
  assign gp_mag = gp10[35] ? -gp10 : gp10;
  assign gz10 = ({{4{in_rate_z_raw[15]}}, in_rate_z_raw} <<< 3)
              + ({{4{in_rate_z_raw[15]}}, in_rate_z_raw} <<< 1);
  assign gz_mag = gz10[19] ? -gz10 : gz10;

  assign count_nxt = (count_r == 16'hffff) ? count_r : count_r + 16'd1;

  cfk_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .accel_x (in_accel_x_raw),
    .accel_z (in_accel_z_raw),
    .busy    (cor_busy),
    .angle   (acc_angle)
  );

  cfk_cdiv u_cdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  cfk_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mcand (d),
    .mplr  (blend_r),
    .busy  (mul_busy),
    .prod  (prod)
  );

  // pitch path arithmetic
  assign dq = {1'b0, div_quo[28:0]};
  assign delta = pitch_neg_r ? -dq : dq;
  assign a_nxt = {{2{fp_r[31]}}, fp_r} - {{4{delta[29]}}, delta};
  assign d = {{(34-ACC_W){acc_angle[ACC_W-1]}}, acc_angle} - a_r;

  // yaw path: trunc(rate_z * 10 / 164) * 328
  assign yq = yaw_neg_r ? -$signed({1'b0, div_quo[11:0]}) : $signed({1'b0, div_quo[11:0]});
  assign inc = ({{9{yq[12]}}, yq} <<< 8) + ({{9{yq[12]}}, yq} <<< 6)
             + ({{9{yq[12]}}, yq} <<< 3);
  assign yaw_sum = {yaw_r[39], yaw_r} + {{19{inc[21]}}, inc};
  assign yaw_sat = (yaw_sum[40] != yaw_sum[39])
                 ? (yaw_sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}})
                 : yaw_sum[39:0];

  // blend: (a << 16) + w * (acc - a), rounded and saturated
  assign b = {{2{a_r[33]}}, a_r, 16'b0} + {{(52-PROD_W){prod[PROD_W-1]}}, prod}
           + 52'sd32768;
  assign bs = b[51:16];
  assign fp_sat = (bs[35:31] == 5'b00000 || bs[35:31] == 5'b11111)
                ? bs[31:0] : (bs[35] ? 32'sh80000000 : 32'sh7fffffff);

  assign held_nxt = valid_r ? whole16({{8{fp_r[31]}}, fp_r}) : held_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_PITCH;
      ST_PITCH: if (!div_busy && !cor_busy) state_nxt = ST_YAW;
      ST_YAW:   if (!div_busy) state_nxt = ST_BLEND;
      ST_BLEND: if (!mul_busy) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    div_start = 1'b0;
    div_dividend = gp_mag[DIV_W-1:0] + 36'd82;
    mul_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        div_start = in_valid;
      end
      ST_PITCH: begin
        div_start = !div_busy && !cor_busy;
        div_dividend = {{(DIV_W-19){1'b0}}, yaw_mag_r};
      end
      ST_YAW: begin
        mul_start = !div_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      blend_r <= 16'd229;
      period_r <= 16'd328;
      warmup_r <= 16'd600;
      count_r <= '0;
      fp_r <= '0;
      yaw_r <= '0;
      held_r <= '0;
      valid_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLEND:  blend_r <= cfg_data;
          CFG_PERIOD: period_r <= cfg_data;
          CFG_WARMUP: warmup_r <= cfg_data;
          default:    blend_r <= blend_r;
        endcase
      end
      if (accept) begin
        count_r <= count_nxt;
        valid_r <= (count_nxt > warmup_r);
      end
      if (state_r == ST_YAW && !div_busy) begin
        yaw_r <= yaw_sat;
      end
      if (state_r == ST_BLEND && !mul_busy) begin
        fp_r <= fp_sat;
      end
      if (state_r == ST_DONE) begin
        held_r <= held_nxt;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      pitch_neg_r <= gp10[35];
      yaw_neg_r <= gz10[19];
      yaw_mag_r <= gz_mag[18:0];
    end
    if (state_r == ST_PITCH && !div_busy && !cor_busy) begin
      a_r <= a_nxt;
    end
    if (state_r == ST_DONE && out_free) begin
      out_pitch_deg <= held_nxt;
      out_yaw_deg <= whole16(yaw_r);
      out_pitch_valid <= valid_r;
    end
  end

  property p_accept_starts_units;
    @(posedge clk) disable iff (!rst_n) accept |=> (state_r == ST_PITCH) && div_busy && cor_busy;
  endproperty
  a_accept_starts_units: assert property (p_accept_starts_units)
    else $error("sample taken without starting the divider and cordic");

  property p_blend_after_divides;
    @(posedge clk) disable iff (!rst_n) (state_r == ST_BLEND) |-> !div_busy && !cor_busy;
  endproperty
  a_blend_after_divides: assert property (p_blend_after_divides)
    else $error("blend running while a divide or cordic run is active");

  property p_word_only_from_done;
    @(posedge clk) disable iff (!rst_n) $rose(out_valid) |-> $past(state_r == ST_DONE);
  endproperty
  a_word_only_from_done: assert property (p_word_only_from_done)
    else $error("result word raised outside the finish step");

endmodule
